@@ hw/rtl/overbright_pixel_gain_clamp_macros.svh @@
// Assertion macros shared by the overbright pixel gain clamp RTL.
`ifndef OVERBRIGHT_PIXEL_GAIN_CLAMP_MACROS_SVH
`define OVERBRIGHT_PIXEL_GAIN_CLAMP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define OPGC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define OPGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define OPGC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define OPGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/opgc_pkg.sv @@
// Types, constants and the divider step of the overbright pixel gain clamp.
package opgc_pkg;

	localparam int CHAN_W  = 8;
	localparam int GAIN_W  = 12;
	localparam int PROD_W  = CHAN_W + GAIN_W;
	localparam int NUM_CH  = 3;

	// Channel slots inside the pipeline.
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	// Register indexes of the configuration port.
	localparam logic REG_OVERBRIGHT_ON = 1'b0;
	localparam logic REG_GAIN_Q4_8     = 1'b1;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd256;

	// 255.0 in Q.8: a product above this overflows the channel.
	localparam logic [PROD_W-1:0] FULL_SCALE_Q8 = 20'd65280;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

	// One divider lane: partial remainder, numerator bits still to shift in,
	// and the quotient built so far.
	typedef struct packed {
		logic [CHAN_W-1:0] rem;
		logic [CHAN_W-1:0] lo;
		logic [CHAN_W-1:0] quo;
	} div_lane_t;

	// Everything a divider stage carries for one pixel.
	typedef struct packed {
		logic                           over;
		logic [CHAN_W-1:0]              maxc;
		div_lane_t [NUM_CH-1:0]         lane;
		logic [NUM_CH-1:0][CHAN_W-1:0]  trunc;
	} div_stage_t;

	// Two restoring-division steps on every lane: 255*c / max.
	function automatic div_stage_t div_step2(input div_stage_t d);
		div_stage_t r;
		logic [CHAN_W:0] part;
		r = d;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			for (int k = 0; k < 2; k++) begin
				part = {r.lane[ch].rem, r.lane[ch].lo[CHAN_W-1]};
				r.lane[ch].lo = {r.lane[ch].lo[CHAN_W-2:0], 1'b0};
				if (part >= {1'b0, r.maxc}) begin
					r.lane[ch].rem = CHAN_W'(part - {1'b0, r.maxc});
					r.lane[ch].quo = {r.lane[ch].quo[CHAN_W-2:0], 1'b1};
				end else begin
					r.lane[ch].rem = part[CHAN_W-1:0];
					r.lane[ch].quo = {r.lane[ch].quo[CHAN_W-2:0], 1'b0};
				end
			end
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/overbright_pixel_gain_clamp.sv @@
// Overbright pixel gain clamp: seven-stage pipeline.
// The block takes a pixel as blue, green and red bytes and returns it as red,
// green, blue. With overbright on, every channel is multiplied by the Q4.8
// gain; if any product goes above 255.0 the pixel is instead scaled to
// floor(255*c/max) so the hue is kept, otherwise each product is truncated.
// With overbright off the channels are only reordered. The pipeline takes one
// pixel per clock unless the output stalls; the edge that accepts a pixel loads
// the first stage, and its result passes stages two to seven on to out_valid.
// The first stage holds the three gain multipliers, the second the overflow
// test and channel maximum, four stages form the divider at two quotient bits
// each, and the last stage picks the result. Each stage stalls on its own, so
// bubbles close up while the output waits. Configuration is taken at once and
// should be written only while the pipeline is empty.
`include "overbright_pixel_gain_clamp_macros.svh"

module overbright_pixel_gain_clamp (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [opgc_pkg::GAIN_W-1:0]    cfg_wdata,
	// Input pixel channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [opgc_pkg::CHAN_W-1:0]    in_blue,
	input  logic [opgc_pkg::CHAN_W-1:0]    in_green,
	input  logic [opgc_pkg::CHAN_W-1:0]    in_red,
	// Output pixel channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [opgc_pkg::CHAN_W-1:0]    out_red,
	output logic [opgc_pkg::CHAN_W-1:0]    out_green,
	output logic [opgc_pkg::CHAN_W-1:0]    out_blue
);

	// Configuration registers.
	logic                          overbright_on_q;
	logic [opgc_pkg::GAIN_W-1:0]   gain_q;

	// Stage valid bits and per-stage advance enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	// Stage payloads.
	logic [opgc_pkg::NUM_CH-1:0][opgc_pkg::CHAN_W-1:0] chan_s1;
	logic [opgc_pkg::NUM_CH-1:0][opgc_pkg::PROD_W-1:0] prod_s1;
	logic                                              on_s1;
	opgc_pkg::div_stage_t div_s2, div_s3, div_s4, div_s5, div_s6;
	logic [opgc_pkg::NUM_CH-1:0][opgc_pkg::CHAN_W-1:0] pix_s7;

	// Combinational stage inputs.
	logic [opgc_pkg::NUM_CH-1:0][opgc_pkg::CHAN_W-1:0] chan_d;
	logic [opgc_pkg::NUM_CH-1:0][opgc_pkg::PROD_W-1:0] prod_d;
	opgc_pkg::div_stage_t                              div_d;
	logic [opgc_pkg::CHAN_W-1:0]                       max_rg;
	logic [2*opgc_pkg::CHAN_W-1:0]                     numer;
	logic [opgc_pkg::NUM_CH-1:0][opgc_pkg::CHAN_W-1:0] pix_d;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overbright_on_q <= 1'b0;
			gain_q          <= opgc_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				opgc_pkg::REG_OVERBRIGHT_ON: overbright_on_q <= cfg_wdata[0];
				opgc_pkg::REG_GAIN_Q4_8:     gain_q          <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// A stage advances when it is empty or the next one advances.
	assign en_s7    = !v_s7 || out_ready;
	assign en_s6    = !v_s6 || en_s7;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// Stage 1: reorder channels and multiply each by the gain.
	always_comb begin
		chan_d[opgc_pkg::CH_RED]   = in_red;
		chan_d[opgc_pkg::CH_GREEN] = in_green;
		chan_d[opgc_pkg::CH_BLUE]  = in_blue;
		for (int ch = 0; ch < opgc_pkg::NUM_CH; ch++) begin
			prod_d[ch] = opgc_pkg::PROD_W'(chan_d[ch]) * opgc_pkg::PROD_W'(gain_q);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			chan_s1 <= chan_d;
			prod_s1 <= prod_d;
			on_s1   <= overbright_on_q;
		end
	end

	// Stage 2: overflow test, channel maximum, and divider set-up.
	always_comb begin
		max_rg = (chan_s1[opgc_pkg::CH_RED] > chan_s1[opgc_pkg::CH_GREEN]) ?
			chan_s1[opgc_pkg::CH_RED] : chan_s1[opgc_pkg::CH_GREEN];
		div_d.maxc = (chan_s1[opgc_pkg::CH_BLUE] > max_rg) ?
			chan_s1[opgc_pkg::CH_BLUE] : max_rg;
		div_d.over = on_s1 && ((prod_s1[opgc_pkg::CH_RED]   > opgc_pkg::FULL_SCALE_Q8) ||
		                       (prod_s1[opgc_pkg::CH_GREEN] > opgc_pkg::FULL_SCALE_Q8) ||
		                       (prod_s1[opgc_pkg::CH_BLUE]  > opgc_pkg::FULL_SCALE_Q8));
		numer = '0;
		for (int ch = 0; ch < opgc_pkg::NUM_CH; ch++) begin
			// 255*c as c*256 - c; the high byte is below max, so it seeds the remainder.
			numer = {chan_s1[ch], {opgc_pkg::CHAN_W{1'b0}}} -
				(2*opgc_pkg::CHAN_W)'(chan_s1[ch]);
			div_d.lane[ch].rem = numer[2*opgc_pkg::CHAN_W-1:opgc_pkg::CHAN_W];
			div_d.lane[ch].lo  = numer[opgc_pkg::CHAN_W-1:0];
			div_d.lane[ch].quo = '0;
			div_d.trunc[ch]    = on_s1 ?
				prod_s1[ch][2*opgc_pkg::CHAN_W-1:opgc_pkg::CHAN_W] : chan_s1[ch];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) div_s2 <= div_d;
	end

	// Stages 3 to 6: restoring divider, two quotient bits per stage.
	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) div_s3 <= opgc_pkg::div_step2(div_s2);
		if (en_s4 && v_s3) div_s4 <= opgc_pkg::div_step2(div_s3);
		if (en_s5 && v_s4) div_s5 <= opgc_pkg::div_step2(div_s4);
		if (en_s6 && v_s5) div_s6 <= opgc_pkg::div_step2(div_s5);
	end

	// Stage 7: pick the hue-preserving quotient or the truncated product.
	always_comb begin
		for (int ch = 0; ch < opgc_pkg::NUM_CH; ch++) begin
			pix_d[ch] = div_s6.over ? div_s6.lane[ch].quo : div_s6.trunc[ch];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7 && v_s6) pix_s7 <= pix_d;
	end

	assign out_valid = v_s7;
	assign out_red   = pix_s7[opgc_pkg::CH_RED];
	assign out_green = pix_s7[opgc_pkg::CH_GREEN];
	assign out_blue  = pix_s7[opgc_pkg::CH_BLUE];

	// An accepted item always lands in the first stage.
	`OPGC_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && in_ready, v_s1)

	// Overflow needs a nonzero maximum, so the divider never divides by zero.
	`OPGC_ASSERT_SAME(a_over_max_nonzero, clk, arst_n, v_s2 && div_s2.over, div_s2.maxc != '0)

	// Partial remainders stay below the divisor.
	`OPGC_ASSERT_SAME(a_rem_below_max, clk, arst_n, v_s4 && div_s4.over, (div_s4.lane[0].rem < div_s4.maxc) && (div_s4.lane[1].rem < div_s4.maxc) && (div_s4.lane[2].rem < div_s4.maxc))

	// After clamping, the brightest channel reaches full scale.
	`OPGC_ASSERT_SAME(a_clamp_full_scale, clk, arst_n, v_s6 && div_s6.over, (div_s6.lane[0].quo == opgc_pkg::CHAN_MAX) || (div_s6.lane[1].quo == opgc_pkg::CHAN_MAX) || (div_s6.lane[2].quo == opgc_pkg::CHAN_MAX))

endmodule
